// ----- hw/rtl/scfh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfh_pkg
// Shared types and constants of the serial command frame handler.
// ----------------------------------------------------------------------------
package scfh_pkg;

    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 7;
    localparam int NUM_CFG  = 7;
    localparam int CFG_IDX_W = $clog2(NUM_CFG + 1);
    localparam int CHAN_W   = 2;

    localparam logic [BYTE_W-1:0] START_MARK = 8'h24;

    // s_tdata layout
    localparam int S_TDATA_W = 64;
    // m_tdata layout: value, code, duty update, duty channel, padded to bytes
    localparam int M_TDATA_USED = BYTE_W + CODE_W + 1 + CHAN_W;
    localparam int M_TDATA_W    = ((M_TDATA_USED + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2,
        PH_CHK  = 2'd3
    } phase_t;

    // register index order doubles as target priority
    typedef enum logic [CFG_IDX_W-1:0] {
        TGT_RED    = 3'd0,
        TGT_GREEN  = 3'd1,
        TGT_BLUE   = 3'd2,
        TGT_TEMP   = 3'd3,
        TGT_LIGHT  = 3'd4,
        TGT_FLAME  = 3'd5,
        TGT_MOTION = 3'd6
    } target_t;

    typedef logic [NUM_CFG-1:0][CODE_W-1:0] code_arr_t;

    localparam code_arr_t CODE_RESET = {7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1};

    typedef struct packed {
        logic [CHAN_W-1:0] duty_channel;
        logic              duty_update;
        logic [CODE_W-1:0] reply_code;
        logic              reply_group;
        logic [BYTE_W-1:0] reply_value;
    } reply_t;

    typedef struct packed {
        logic              reply_ok;
        logic              duty_we;
        logic [CHAN_W-1:0] duty_sel;
    } dec_ctl_t;

endpackage

// ----- hw/rtl/scfh_cmd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfh_cmd_decode
// Checks a completed frame and works out its reply and any duty write.
// ----------------------------------------------------------------------------
module scfh_cmd_decode (
    input  logic                      frame_end,
    input  logic [7:0]                held_cmd,
    input  logic [7:0]                held_data,
    input  logic [7:0]                chk_byte,
    input  scfh_pkg::code_arr_t       codes,
    input  logic [7:0]                red_duty,
    input  logic [7:0]                green_duty,
    input  logic [7:0]                blue_duty,
    input  logic [7:0]                temp_low,
    input  logic [7:0]                light_low,
    input  logic [7:0]                flame_low,
    input  logic [7:0]                motion_val,
    output scfh_pkg::dec_ctl_t        ctl,
    output scfh_pkg::reply_t          reply
);
    import scfh_pkg::*;

    logic [BYTE_W-1:0] sum;
    logic [CODE_W-1:0] code;
    logic              is_write;
    logic              hit;
    target_t           tgt;

    assign sum      = held_cmd + held_data;
    assign code     = held_cmd[CODE_W-1:0];
    assign is_write = held_cmd[BYTE_W-1];

    // first matching register wins
    always_comb begin
        hit = 1'b0;
        tgt = TGT_RED;
        for (int k = 0; k < NUM_CFG; k++) begin
            if (!hit && codes[CFG_IDX_W'(k)] == code) begin
                hit = 1'b1;
                tgt = target_t'(CFG_IDX_W'(k));
            end
        end
    end

    always_comb begin
        ctl                = '0;
        reply              = '0;
        reply.reply_code   = code;
        if (frame_end && chk_byte == sum && hit) begin
            if (is_write) begin
                if (tgt == TGT_RED || tgt == TGT_GREEN || tgt == TGT_BLUE) begin
                    ctl.reply_ok       = 1'b1;
                    ctl.duty_we        = 1'b1;
                    ctl.duty_sel       = tgt[CHAN_W-1:0];
                    reply.reply_value  = held_data;
                    reply.duty_update  = 1'b1;
                    reply.duty_channel = tgt[CHAN_W-1:0];
                end
            end else begin
                ctl.reply_ok = 1'b1;
                unique case (tgt)
                    TGT_RED:    reply.reply_value = red_duty;
                    TGT_GREEN:  reply.reply_value = green_duty;
                    TGT_BLUE:   reply.reply_value = blue_duty;
                    TGT_TEMP:   reply.reply_value = temp_low;
                    TGT_LIGHT:  reply.reply_value = light_low;
                    TGT_FLAME:  reply.reply_value = flame_low;
                    TGT_MOTION: reply.reply_value = motion_val;
                    default:    reply.reply_value = motion_val;
                endcase
                reply.reply_group = !(tgt == TGT_RED || tgt == TGT_GREEN ||
                                      tgt == TGT_BLUE);
            end
        end
    end

endmodule

// ----- hw/rtl/serial_command_frame_handler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_handler_top
// Parses '$' command frames from a byte stream and answers LED and sensor
// commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received byte per transfer together with the
//   current sensor samples. A frame is '$', command, data, checksum; the
//   checksum byte must equal (command + data) mod 256.
//   m_ channel carries at most one reply per frame, issued for the transfer
//   of the checksum byte. Bad checksums, unknown codes and writes to sensor
//   codes give no reply.
//   cfg_we / cfg_index / cfg_wdata set the seven command codes; write them
//   only while no frame is being replied to.
// Rate and output timing:
//   one byte per cycle while s_tready is high; a reply is captured in the output
//   register in the cycle after its checksum byte transfer. Parsing and decode sit
//   between the frame state registers and that output register.
// Reset:
//   hunts for a start mark, all duties zero, codes 1..7 for red, green,
//   blue, temperature, light, flame, motion.
// Stall:
//   while a reply waits on m_tready low, s_tready drops; a taken reply frees
//   the register in the same cycle.
// ----------------------------------------------------------------------------
module serial_command_frame_handler_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // rx_byte[7:0], light_sample[23:8], temp_sample[39:24],
    // flame_sample[55:40], motion_value[63:56]
    input  logic [scfh_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // reply_value[7:0], reply_code[14:8], duty_update[15], duty_channel[17:16]
    output logic [scfh_pkg::M_TDATA_W-1:0]    m_tdata,
    // reply_group[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [scfh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scfh_pkg::CODE_W-1:0]       cfg_wdata
);
    import scfh_pkg::*;

    code_arr_t          codes_reg;
    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [BYTE_W-1:0]  red_reg;
    logic [BYTE_W-1:0]  green_reg;
    logic [BYTE_W-1:0]  blue_reg;
    logic               m_tvalid_reg;
    reply_t             reply_reg;

    logic [BYTE_W-1:0]  rx_byte;
    logic               s_fire;
    dec_ctl_t           dec_ctl;
    reply_t             dec_reply;

    assign rx_byte  = s_tdata[7:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // configuration codes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg <= CODE_RESET;
        end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
            codes_reg[cfg_index] <= cfg_wdata;
        end
    end

    // frame phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: if (rx_byte == START_MARK) phase_next = PH_CMD;
            PH_CMD:  phase_next = PH_DATA;
            PH_DATA: phase_next = PH_CHK;
            PH_CHK:  phase_next = PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else if (s_fire) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && phase_reg == PH_CMD) begin
            cmd_reg <= rx_byte;
        end
        if (s_fire && phase_reg == PH_DATA) begin
            data_reg <= rx_byte;
        end
    end

    scfh_cmd_decode u_decode (
        .frame_end  (phase_reg == PH_CHK),
        .held_cmd   (cmd_reg),
        .held_data  (data_reg),
        .chk_byte   (rx_byte),
        .codes      (codes_reg),
        .red_duty   (red_reg),
        .green_duty (green_reg),
        .blue_duty  (blue_reg),
        .temp_low   (s_tdata[31:24]),
        .light_low  (s_tdata[15:8]),
        .flame_low  (s_tdata[47:40]),
        .motion_val (s_tdata[63:56]),
        .ctl        (dec_ctl),
        .reply      (dec_reply)
    );

    // led duties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end else if (s_fire && dec_ctl.duty_we) begin
            case (dec_ctl.duty_sel)
                CHAN_W'(TGT_RED):   red_reg   <= data_reg;
                CHAN_W'(TGT_GREEN): green_reg <= data_reg;
                default:            blue_reg  <= data_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= dec_ctl.reply_ok;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && dec_ctl.reply_ok) begin
            reply_reg <= dec_reply;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = reply_reg.reply_group;
    assign m_tdata  = {{(M_TDATA_W - M_TDATA_USED){1'b0}},
                       reply_reg.duty_channel,
                       reply_reg.duty_update,
                       reply_reg.reply_code,
                       reply_reg.reply_value};

endmodule

// ----- hw/rtl/scfh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfh_checker
// Port-level checks of the serial command frame handler.
// ----------------------------------------------------------------------------
module scfh_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [scfh_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [scfh_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [0:0]                        m_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [scfh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scfh_pkg::CODE_W-1:0]       cfg_wdata
);
    import scfh_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_tdata, cfg_we, cfg_index, cfg_wdata};

    // stalled reply holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("reply changed while stalled");

    // a duty update is always a control group reply on a real led
    a_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> !m_tuser[0] && m_tdata[17:16] != 2'd3)
        else $error("bad duty update reply");

    // no channel without an update
    a_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[15] |-> m_tdata[17:16] == 2'd0)
        else $error("duty channel set without update");

    // a new reply comes only from an input transfer
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("reply without input transfer");

    // output empty right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("reply valid after reset");

endmodule

bind serial_command_frame_handler_top scfh_checker u_scfh_checker (.*);
